// ===== src/bdl_pkg.sv =====
// bdl_pkg: shared types, constants and helpers for bilinear_downscale_lut
// no dependencies
`timescale 1ns / 1ps

package bdl_pkg;

  localparam int MaxLine = 512;
  localparam int TableDepth = 2048;
  localparam int FracBits = 16;
  localparam int PosW = 26;
  localparam int DimW = 10;
  localparam int ColW = 10;
  localparam int TabAw = 11;
  localparam int PaddrW = 5;

  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};
  localparam logic [FracBits:0] OneFx = {1'b1, {FracBits{1'b0}}};

  // register indexes
  localparam logic [2:0] RegSrcW = 3'd0;
  localparam logic [2:0] RegSrcH = 3'd1;
  localparam logic [2:0] RegOutW = 3'd2;
  localparam logic [2:0] RegOutH = 3'd3;
  localparam logic [2:0] RegStepH = 3'd4;
  localparam logic [2:0] RegStepV = 3'd5;

  typedef struct packed {
    logic [DimW-1:0] src_w;
    logic [DimW-1:0] src_h;
    logic [DimW-1:0] out_w;
    logic [DimW-1:0] out_h;
    logic [PosW-1:0] step_h;
    logic [PosW-1:0] step_v;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic            pix_go;     // stage 1: sample enters
    logic            tab_wr;     // table write
    logic [ColW-1:0] col;        // source column for line store
    logic [FracBits-1:0] fv;
    logic [FracBits-1:0] fh;
    logic            emit;       // produce output for this pixel
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } sts_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    if (v == '0) return DimW'(1);
    if (v > DimW'(MaxLine)) return DimW'(MaxLine);
    return v;
  endfunction

  function automatic logic [PosW-1:0] start_pos(input logic [PosW-1:0] step);
    logic [PosW-1:0] half;
    half = step >> 1;
    if (half >= PosW'(OneFx >> 1)) return half - PosW'(OneFx >> 1);
    return '0;
  endfunction

  function automatic logic [PosW-1:0] advance(input logic [PosW-1:0] p,
                                              input logic [PosW-1:0] s);
    logic [PosW:0] t;
    t = {1'b0, p} + {1'b0, s};
    if (t[PosW]) return PosMax;
    return t[PosW-1:0];
  endfunction

  function automatic logic [PosW-FracBits:0] target(input logic [PosW-1:0] p);
    logic [PosW-FracBits:0] k;
    k = {1'b0, p[PosW-1:FracBits]};
    if (p[FracBits-1:0] != '0) return k + 1'b1;
    return k;
  endfunction

endpackage

// ===== src/bdl_if.sv =====
// bdl_if: valid/ready channels for bilinear_downscale_lut
// depends on bdl_pkg
`timescale 1ns / 1ps

interface bdl_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [10:0] table_address;
  logic [7:0]  table_value;
  logic signed [15:0] sample;
  modport source (output valid, mode, table_address, table_value, sample, input ready);
  modport sink (input valid, mode, table_address, table_value, sample, output ready);
endinterface

interface bdl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] display_pixel;
  logic       frame_last;
  modport source (output valid, display_pixel, frame_last, input ready);
  modport sink (input valid, display_pixel, frame_last, output ready);
endinterface

// ===== src/bdl_ctrl.sv =====
// bdl_ctrl: counter/position controller of bilinear_downscale_lut
// depends on bdl_pkg
`timescale 1ns / 1ps

module bdl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bdl_pkg::cfg_t   cfg_i,
  input  logic            acc_i,
  input  logic            mode_i,
  input  bdl_pkg::sts_t   sts_i,
  output logic            in_ready_o,
  output bdl_pkg::cmd_t   cmd_o
);
  localparam int RowW = 9;
  localparam logic [0:0] StIdle = 1'b0;
  localparam logic [0:0] StBusy = 1'b1;

  logic [0:0] state_q, state_d;
  logic [RowW-1:0] srow_q, srow_d, scol_q, scol_d;
  logic [bdl_pkg::DimW-1:0] orow_q, orow_d, ocol_q, ocol_d;
  logic [bdl_pkg::PosW-1:0] vpos_q, vpos_d, hpos_q, hpos_d;

  logic [bdl_pkg::DimW-1:0] w, h, ow, oh;
  logic [bdl_pkg::PosW-1:0] vp, hp, vp2, hp2;
  logic [bdl_pkg::DimW-1:0] orw, ocl, orw2, ocl2;
  logic active, emit;

  assign w = bdl_pkg::clamp_dim(cfg_i.src_w);
  assign h = bdl_pkg::clamp_dim(cfg_i.src_h);
  assign ow = bdl_pkg::clamp_dim(cfg_i.out_w);
  assign oh = bdl_pkg::clamp_dim(cfg_i.out_h);

  // one pixel in flight at a time: accept when nothing is busy
  assign in_ready_o = (state_q == StIdle) && !sts_i.busy;

  always_comb begin
    vp = vpos_q;
    orw = orow_q;
    hp = hpos_q;
    ocl = ocol_q;
    if (srow_q == '0 && scol_q == '0) begin
      orw = '0;
      vp = bdl_pkg::start_pos(cfg_i.step_v);
    end
    if (scol_q == '0) begin
      ocl = '0;
      hp = bdl_pkg::start_pos(cfg_i.step_h);
    end
    active = (orw < oh) &&
             ({2'b0, srow_q} >= 11'(bdl_pkg::target(vp)));
    emit = active && (ocl < ow) &&
           ({2'b0, scol_q} >= 11'(bdl_pkg::target(hp)));
    vp2 = vp;
    hp2 = hp;
    orw2 = orw;
    ocl2 = ocl;
    if (emit) begin
      ocl2 = ocl + 1'b1;
      hp2 = bdl_pkg::advance(hp, cfg_i.step_h);
      if (ocl2 >= ow) begin
        orw2 = orw + 1'b1;
        vp2 = bdl_pkg::advance(vp, cfg_i.step_v);
      end
    end
    if ({1'b0, scol_q} + 1'b1 >= w) begin
      if (active && ocl2 < ow) begin
        orw2 = orw2 + 1'b1;
        vp2 = bdl_pkg::advance(vp2, cfg_i.step_v);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    srow_d = srow_q;
    scol_d = scol_q;
    orow_d = orow_q;
    ocol_d = ocol_q;
    vpos_d = vpos_q;
    hpos_d = hpos_q;
    unique case (state_q)
      StIdle: begin
        if (acc_i && mode_i) state_d = StBusy;
      end
      StBusy: begin
        // commit the counter update for the pixel taken last cycle
        state_d = StIdle;
        orow_d = orw2;
        ocol_d = ocl2;
        vpos_d = vp2;
        hpos_d = hp2;
        if ({1'b0, scol_q} + 1'b1 >= w) begin
          scol_d = '0;
          if ({1'b0, srow_q} + 1'b1 >= h) srow_d = '0;
          else srow_d = srow_q + 1'b1;
        end else begin
          scol_d = scol_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      srow_q <= '0;
      scol_q <= '0;
      orow_q <= '0;
      ocol_q <= '0;
      vpos_q <= bdl_pkg::start_pos(bdl_pkg::PosW'(111848));
      hpos_q <= bdl_pkg::start_pos(bdl_pkg::PosW'(111848));
    end else begin
      state_q <= state_d;
      srow_q <= srow_d;
      scol_q <= scol_d;
      orow_q <= orow_d;
      ocol_q <= ocol_d;
      vpos_q <= vpos_d;
      hpos_q <= hpos_d;
    end
  end

  always_comb begin
    cmd_o.pix_go = acc_i && mode_i;
    cmd_o.tab_wr = acc_i && !mode_i;
    cmd_o.col = {1'b0, scol_q};
    cmd_o.fv = vp[bdl_pkg::FracBits-1:0];
    cmd_o.fh = hp[bdl_pkg::FracBits-1:0];
    cmd_o.emit = emit && (state_q == StBusy);
    cmd_o.last = (orw == oh - 1'b1) && (ocl == ow - 1'b1);
  end
endmodule

// ===== src/bdl_datapath.sv =====
// bdl_datapath: line store, interpolation pipeline, table and output register
// depends on bdl_pkg
`timescale 1ns / 1ps

module bdl_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bdl_pkg::cmd_t     cmd_i,
  input  logic [10:0]       tab_addr_i,
  input  logic [7:0]        tab_val_i,
  input  logic signed [15:0] sample_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [7:0]        pixel_o,
  output logic              last_o,
  output bdl_pkg::sts_t     sts_o
);
  localparam int Fb = bdl_pkg::FracBits;

  logic [15:0] line_mem [bdl_pkg::MaxLine];
  logic [7:0]  tab_mem [bdl_pkg::TableDepth];

  // stage 1: sample held, line store read
  logic signed [15:0] smp_q, lo_rd_q;
  logic s1_q, s2_q, s3_q;
  logic signed [23:0] prev_q, vval_q;
  logic signed [Fb+1:0] fv1, fv0, fh1, fh0;
  logic signed [15:0] lo;
  logic signed [Fb+17:0] vsum;
  logic signed [Fb+25:0] hsum;
  logic signed [23:0] a_s;
  logic [10:0] idx_q;
  logic emit_q, last_q;
  logic out_v_q, emit2_q, last2_q;
  logic [bdl_pkg::FracBits-1:0] fh_q;
  logic [7:0] pix_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tab_wr) tab_mem[tab_addr_i] <= tab_val_i;
    if (cmd_i.pix_go) begin
      lo_rd_q <= line_mem[cmd_i.col[8:0]];
      line_mem[cmd_i.col[8:0]] <= sample_i;
      smp_q <= sample_i;
    end
  end

  // stage 2: vertical blend (runs in controller's busy cycle)
  always_comb begin
    lo = (cmd_i.fv == '0) ? smp_q : lo_rd_q;
    fv1 = {2'b0, cmd_i.fv};
    fv0 = (Fb+2)'(bdl_pkg::OneFx) - fv1;
    vsum = lo * fv0 + smp_q * fv1;
  end

  always_ff @(posedge clk_i) begin
    if (s1_q) begin
      vval_q <= 24'(vsum >>> (Fb - 8));
      emit_q <= cmd_i.emit;
      last_q <= cmd_i.last;
      fh_q <= cmd_i.fh;
    end
    if (s2_q) prev_q <= vval_q;
  end

  // stage 3: horizontal blend and index clamp
  always_comb begin
    a_s = (fh_q == '0) ? vval_q : prev_q;
    fh1 = {2'b0, fh_q};
    fh0 = (Fb+2)'(bdl_pkg::OneFx) - fh1;
    hsum = a_s * fh0 + vval_q * fh1;
  end

  always_ff @(posedge clk_i) begin
    if (s2_q) begin
      if (hsum <= 0) idx_q <= '0;
      else if ((hsum >>> (Fb + 8)) > (Fb+26)'(bdl_pkg::TableDepth - 1))
        idx_q <= 11'(bdl_pkg::TableDepth - 1);
      else idx_q <= 11'(hsum >>> (Fb + 8));
      emit2_q <= emit_q;
      last2_q <= last_q;
    end
    if (s3_q) pix_q <= tab_mem[idx_q];
    if (s3_q) last_o <= last2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
      s3_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_q <= cmd_i.pix_go;
      s2_q <= s1_q;
      s3_q <= s2_q && emit_q;
      if (s3_q) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  assign pixel_o = pix_q;
  assign out_valid_o = out_v_q;
  // hold off input while a pixel is in flight or a result waits
  assign sts_o.busy = s1_q | s2_q | s3_q | (out_v_q & !out_ready_i);
endmodule

// ===== src/bilinear_downscale_lut.sv =====
// bilinear_downscale_lut: top level, config registers, controller and datapath
// depends on bdl_pkg, bdl_if, bdl_ctrl, bdl_datapath
//
// channel   direction  content
// in_if     sink       mode, table_address, table_value, sample
// out_if    source     display_pixel, frame_last
// apb       slave      six config registers at 4*i
//
// a source pixel passes line read, vertical blend, horizontal blend and table read before its
// result shows valid; the next request is taken only once the pixel has left the pipeline;
// a table write does not hold the next request back
// reset clears counters and sets positions to the start for the default step; line store and table stay unwritten
// a held result stalls input until it is taken
`timescale 1ns / 1ps

module bilinear_downscale_lut (
  input  logic        clk_i,
  input  logic        rst_ni,
  bdl_in_if.sink      in_if,
  bdl_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  bdl_pkg::cfg_t cfg_q;
  bdl_pkg::cmd_t cmd;
  bdl_pkg::sts_t sts;
  logic acc;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_w <= 10'd512;
      cfg_q.src_h <= 10'd512;
      cfg_q.out_w <= 10'd300;
      cfg_q.out_h <= 10'd300;
      cfg_q.step_h <= 26'd111848;
      cfg_q.step_v <= 26'd111848;
    end else if (psel && penable && pwrite) begin
      priority case (ridx)
        bdl_pkg::RegSrcW: cfg_q.src_w <= pwdata[9:0];
        bdl_pkg::RegSrcH: cfg_q.src_h <= pwdata[9:0];
        bdl_pkg::RegOutW: cfg_q.out_w <= pwdata[9:0];
        bdl_pkg::RegOutH: cfg_q.out_h <= pwdata[9:0];
        bdl_pkg::RegStepH: cfg_q.step_h <= pwdata[25:0];
        bdl_pkg::RegStepV: cfg_q.step_v <= pwdata[25:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      bdl_pkg::RegSrcW: prdata = 32'(cfg_q.src_w);
      bdl_pkg::RegSrcH: prdata = 32'(cfg_q.src_h);
      bdl_pkg::RegOutW: prdata = 32'(cfg_q.out_w);
      bdl_pkg::RegOutH: prdata = 32'(cfg_q.out_h);
      bdl_pkg::RegStepH: prdata = 32'(cfg_q.step_h);
      bdl_pkg::RegStepV: prdata = 32'(cfg_q.step_v);
      default: prdata = '0;
    endcase
  end

  assign acc = in_if.valid && in_if.ready;

  bdl_ctrl u_ctrl (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .acc_i(acc), .mode_i(in_if.mode),
    .sts_i(sts), .in_ready_o(in_if.ready), .cmd_o(cmd)
  );

  bdl_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .tab_addr_i(in_if.table_address),
    .tab_val_i(in_if.table_value), .sample_i(in_if.sample),
    .out_ready_i(out_if.ready), .out_valid_o(out_if.valid),
    .pixel_o(out_if.display_pixel), .last_o(out_if.frame_last), .sts_o(sts)
  );
endmodule

// ===== src/bdl_checker.sv =====
// bdl_checker: port-level checks for bilinear_downscale_lut
// depends on bdl_if
`timescale 1ns / 1ps

module bdl_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [7:0] out_pixel
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel))
    else $error("result dropped under stall");
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !out_valid || $past(out_valid))
    else $error("result too soon");
endmodule

bind bilinear_downscale_lut bdl_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_pixel(out_if.display_pixel)
);

// ===== test/tb_bilinear_downscale_lut.sv =====
// tb_bilinear_downscale_lut: self-checking testbench for the bilinear down-scaler with table
// depends on bdl_pkg, bdl_if and the bilinear_downscale_lut rtl
`timescale 1ns / 1ps

module tb_bilinear_downscale_lut;

  localparam int ClkHalf = 6;
  localparam int CycleLimit = 900000;
  localparam int DrainCycles = 12;
  // low table entries that random samples can reach
  localparam int LutFill = 256;

  typedef enum logic {ModeTable = 1'b0, ModePixel = 1'b1} mode_e;

  typedef struct {
    logic [7:0] pixel;
    logic       last;
  } disp_t;

  // directed row: request plus optional typed-in result
  typedef struct {
    mode_e             mode;
    logic [10:0]       addr;
    logic [7:0]        val;
    logic signed [15:0] smp;
    logic              has_exp;
    logic [7:0]        exp_pixel;
    logic              exp_last;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  bdl_in_if  in_ch();
  bdl_out_if out_ch();

  bilinear_downscale_lut dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // predictor state
  logic [bdl_pkg::DimW-1:0] m_srcw, m_srch, m_outw, m_outh;
  logic [bdl_pkg::PosW-1:0] m_steph, m_stepv;
  logic signed [15:0] m_line [bdl_pkg::MaxLine];
  logic [7:0] m_lut [bdl_pkg::TableDepth];
  int unsigned m_srow, m_scol, m_orow, m_ocol;
  logic [bdl_pkg::PosW-1:0] m_vpos, m_hpos;
  longint m_prev;

  disp_t pixel_queue[$];
  int    failures = 0;
  bit    out_stall_on = 1;
  bit    in_gap_on = 1;
  longint cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("bilinear_downscale_lut regression: fail");
      $finish;
    end
  end

  function automatic int unsigned dim_of(logic [bdl_pkg::DimW-1:0] v);
    if (v == 0) return 1;
    if (v > bdl_pkg::MaxLine) return bdl_pkg::MaxLine;
    return v;
  endfunction

  function automatic logic [bdl_pkg::PosW-1:0] first_pos(logic [bdl_pkg::PosW-1:0] step);
    logic [bdl_pkg::PosW-1:0] half;
    half = step >> 1;
    return (half >= 32768) ? half - 32768 : '0;
  endfunction

  function automatic logic [bdl_pkg::PosW-1:0] step_pos(logic [bdl_pkg::PosW-1:0] p,
                                                        logic [bdl_pkg::PosW-1:0] s);
    longint t;
    t = longint'(p) + longint'(s);
    return (t > 64'h3FFFFFF) ? 26'h3FFFFFF : t[bdl_pkg::PosW-1:0];
  endfunction

  function automatic int unsigned aim(logic [bdl_pkg::PosW-1:0] p);
    return (p[15:0] != 0) ? p[bdl_pkg::PosW-1:16] + 1 : p[bdl_pkg::PosW-1:16];
  endfunction

  // one request through the scaler model; pushes a display pixel when one is due
  function automatic void scale_request(mode_e md, logic [10:0] addr, logic [7:0] val,
                                        logic signed [15:0] smp);
    int unsigned w, h, ow, oh;
    longint lo, vsum, vval, a, s, idx;
    logic [15:0] fv, fh;
    bit active;
    disp_t d;
    if (md == ModeTable) begin
      m_lut[addr] = val;
      return;
    end
    w = dim_of(m_srcw); h = dim_of(m_srch);
    ow = dim_of(m_outw); oh = dim_of(m_outh);
    if (m_srow == 0 && m_scol == 0) begin
      m_orow = 0;
      m_vpos = first_pos(m_stepv);
    end
    if (m_scol == 0) begin
      m_ocol = 0;
      m_hpos = first_pos(m_steph);
    end
    fv = m_vpos[15:0];
    lo = smp;
    if (fv != 0) lo = m_line[m_scol];
    vsum = lo * (65536 - longint'(fv)) + longint'(smp) * longint'(fv) + (64'sd1 <<< 31);
    vval = (vsum >>> 8) - (64'sd1 <<< 23);
    m_line[m_scol] = smp;
    active = m_orow < oh && m_srow >= aim(m_vpos);
    if (active && m_ocol < ow && m_scol >= aim(m_hpos)) begin
      fh = m_hpos[15:0];
      a = (fh == 0) ? vval : m_prev;
      s = a * (65536 - longint'(fh)) + vval * longint'(fh);
      idx = (s > 0) ? (s >>> 24) : 0;
      if (idx > bdl_pkg::TableDepth - 1) idx = bdl_pkg::TableDepth - 1;
      d.pixel = m_lut[idx];
      d.last = (m_orow == oh - 1 && m_ocol == ow - 1);
      pixel_queue.push_back(d);
      m_ocol++;
      m_hpos = step_pos(m_hpos, m_steph);
      if (m_ocol >= ow) begin
        m_orow++;
        m_vpos = step_pos(m_vpos, m_stepv);
      end
    end
    m_prev = vval;
    if (m_scol + 1 >= w) begin
      if (active && m_ocol < ow) begin
        m_orow++;
        m_vpos = step_pos(m_vpos, m_stepv);
      end
      m_scol = 0;
      m_srow = (m_srow + 1 >= h) ? 0 : m_srow + 1;
    end else begin
      m_scol++;
    end
  endfunction

  // apb write: setup then access
  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      bdl_pkg::RegSrcW:  m_srcw = data[bdl_pkg::DimW-1:0];
      bdl_pkg::RegSrcH:  m_srch = data[bdl_pkg::DimW-1:0];
      bdl_pkg::RegOutW:  m_outw = data[bdl_pkg::DimW-1:0];
      bdl_pkg::RegOutH:  m_outh = data[bdl_pkg::DimW-1:0];
      bdl_pkg::RegStepH: m_steph = data[bdl_pkg::PosW-1:0];
      default:           m_stepv = data[bdl_pkg::PosW-1:0];
    endcase
  endtask

  // geometry change; step = src/out in 16.16, frame counters restart at the next frame
  task automatic set_geometry(int sw, int sh, int ow, int oh);
    reg_write(bdl_pkg::RegSrcW, sw);
    reg_write(bdl_pkg::RegSrcH, sh);
    reg_write(bdl_pkg::RegOutW, ow);
    reg_write(bdl_pkg::RegOutH, oh);
    reg_write(bdl_pkg::RegStepH, (sw * 65536) / ow);
    reg_write(bdl_pkg::RegStepV, (sh * 65536) / oh);
  endtask

  // send one request; a random idle gap may precede it while enabled
  task automatic send(mode_e md, logic [10:0] addr, logic [7:0] val, logic signed [15:0] smp);
    if (in_gap_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= md;
    in_ch.table_address <= addr;
    in_ch.table_value <= val;
    in_ch.sample <= smp;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    scale_request(md, addr, val, smp);
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // fill the low table entries, random or ramp; random samples stay within them
  task automatic load_table(bit ramp);
    for (int i = 0; i < LutFill; i++)
      send(ModeTable, 11'(i), ramp ? 8'(i) : 8'($urandom), 16'sd0);
  endtask

  // whole frames of random pixels; each frame row-complete so line store is written
  task automatic send_frames(int frames);
    int unsigned w, h;
    w = dim_of(m_srcw); h = dim_of(m_srch);
    for (int f = 0; f < frames; f++)
      for (int p = 0; p < w * h; p++)
        send(ModePixel, 11'($urandom), 8'($urandom),
             ($urandom_range(0, 7) == 0) ? 16'(-int'($urandom_range(1, 32768))) :
                                           16'(int'($urandom_range(0, LutFill - 1))));
  endtask

  // result check and random stall on the receiving side
  always @(posedge clk_i) begin
    disp_t e;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pixel_queue.size() == 0) begin
          $error("unexpected display_pixel %0d", out_ch.display_pixel);
          failures++;
        end else begin
          e = pixel_queue.pop_front();
          if (out_ch.display_pixel !== e.pixel) begin
            $error("display_pixel expected %0d actual %0d", e.pixel, out_ch.display_pixel);
            failures++;
          end
          if (out_ch.frame_last !== e.last) begin
            $error("frame_last expected %0d actual %0d", e.last, out_ch.frame_last);
            failures++;
          end
        end
      end
      out_ch.ready <= !(out_stall_on && $urandom_range(0, 4) == 0);
    end
  end

  row_t rows[$];
  row_t r;

  initial begin
    in_ch.valid = 1'b0; in_ch.mode = ModeTable; in_ch.table_address = '0;
    in_ch.table_value = '0; in_ch.sample = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    rst_ni = 1'b0;
    m_srcw = 512; m_srch = 512; m_outw = 300; m_outh = 300;
    m_steph = 111848; m_stepv = 111848;
    m_srow = 0; m_scol = 0; m_orow = 0; m_ocol = 0;
    m_vpos = first_pos(m_stepv); m_hpos = first_pos(m_steph); m_prev = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: 2x2 at unit step, extremes of the sample, table edges
    set_geometry(2, 2, 2, 2);
    // table ends first, then entries 1 and 1024 so indexes read back
    rows.push_back('{ModeTable, 11'd0, 8'h00, 16'sd0, 0, 0, 0});
    rows.push_back('{ModeTable, 11'd2047, 8'hFF, 16'sd0, 0, 0, 0});
    rows.push_back('{ModeTable, 11'd1, 8'h5A, 16'sd0, 0, 0, 0});
    rows.push_back('{ModeTable, 11'd1024, 8'hA5, 16'sd0, 0, 0, 0});
    // unit step: each pixel maps straight through; negative saturates low, huge high
    rows.push_back('{ModePixel, 11'h7FF, 8'hFF, -16'sd32768, 1, 8'h00, 1'b0});
    rows.push_back('{ModePixel, 11'h000, 8'h00, 16'sd32767, 1, 8'hFF, 1'b0});
    rows.push_back('{ModePixel, 11'h000, 8'h00, 16'sd1, 1, 8'h5A, 1'b0});
    rows.push_back('{ModePixel, 11'h000, 8'h00, 16'sd1024, 1, 8'hA5, 1'b1});
    rows.push_back('{ModePixel, 11'h555, 8'hAA, 16'sd2047, 1, 8'hFF, 1'b0});
    rows.push_back('{ModePixel, 11'h2AA, 8'h55, 16'sd0, 1, 8'h00, 1'b0});
    rows.push_back('{ModePixel, 11'h000, 8'h00, -16'sd1, 1, 8'h00, 1'b0});
    rows.push_back('{ModePixel, 11'h000, 8'h00, 16'sd2048, 1, 8'hFF, 1'b1});
    foreach (rows[i]) begin
      r = rows[i];
      send(r.mode, r.addr, r.val, r.smp);
      if (r.has_exp && r.mode == ModePixel && pixel_queue.size() != 0) begin
        // typed-in value replaces the prediction for the row just sent
        pixel_queue[$].pixel = r.exp_pixel;
        pixel_queue[$].last = r.exp_last;
      end
    end
    go_idle();

    // fractional weights, short rows, lagging targets and the 512 extreme
    load_table(0);
    go_idle();
    set_geometry(5, 4, 3, 2);
    send_frames(3);
    go_idle();
    set_geometry(7, 3, 7, 1);
    send_frames(3);
    go_idle();
    set_geometry(6, 6, 1, 1);
    send_frames(2);
    go_idle();
    // step below one starts positions at zero; step large saturates positions
    reg_write(bdl_pkg::RegSrcW, 4); reg_write(bdl_pkg::RegSrcH, 3);
    reg_write(bdl_pkg::RegOutW, 4); reg_write(bdl_pkg::RegOutH, 3);
    reg_write(bdl_pkg::RegStepH, 32768); reg_write(bdl_pkg::RegStepV, 33554431);
    send_frames(2);
    go_idle();
    set_geometry(512, 2, 300, 1);
    send_frames(1);
    go_idle();

    // random geometries, mostly small
    load_table(1);
    go_idle();
    for (int k = 0; k < 8; k++) begin
      int sw, sh, ow, oh;
      sw = $urandom_range(2, 12); sh = $urandom_range(2, 8);
      ow = $urandom_range(1, sw); oh = $urandom_range(1, sh);
      set_geometry(sw, sh, ow, oh);
      if (k == 7) begin
        in_gap_on = 0;
        out_stall_on = 0;
      end
      send_frames(2);
      // sprinkle a few table writes between frames
      repeat (4) send(ModeTable, 11'($urandom), 8'($urandom), 16'($urandom));
      go_idle();
    end

    if (failures == 0) begin
      $display("bilinear_downscale_lut regression: pass");
    end else begin
      $display("bilinear_downscale_lut regression: fail");
    end
    $finish;
  end

endmodule
